// File: rtl/cem_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cem_pkg: shared types and constants of the coolant energy monitor
// Fixed-point limits, sequencer states and the EMA step helper.
// ----------------------------------------------------------------------------
package cem_pkg;

    localparam int DEBOUNCE_LIMIT    = 10;
    localparam int TICK_DIVIDE       = 20;
    localparam int SENSOR_TIMEOUT_MS = 2000;
    localparam int EMA_ALPHA         = 1311;
    localparam int OVERTEMP_LIMIT    = 25600;
    localparam int SENSOR_MAX        = 12800;

    localparam int DIV_W   = 72;
    localparam int DCNT_W  = $clog2(DIV_W + 1);
    localparam int QUO_W   = 32;
    localparam int DEN_W   = 32;
    localparam int CFG_A_W = 3;
    localparam int CFG_D_W = 24;

    typedef enum logic [CFG_A_W-1:0] {
        REG_GRAMS_PER_PULSE = 3'd0,
        REG_HEAT_CAPACITY   = 3'd1,
        REG_MIN_FLOW        = 3'd2,
        REG_MIN_WATER_TEMP  = 3'd3,
        REG_MAX_WATER_TEMP  = 3'd4,
        REG_ALARM_MASK      = 3'd5
    } cfg_reg_t;

    typedef enum logic [23:0] {
        ST_IDLE   = 24'h000001,
        ST_M_INT  = 24'h000002,
        ST_A_INT  = 24'h000004,
        ST_M_IN   = 24'h000008,
        ST_A_IN   = 24'h000010,
        ST_M_OUT  = 24'h000020,
        ST_A_OUT  = 24'h000040,
        ST_M_MASS = 24'h000080,
        ST_A_MASS = 24'h000100,
        ST_M_A    = 24'h000200,
        ST_S_A    = 24'h000400,
        ST_M_HI   = 24'h000800,
        ST_S_HI   = 24'h001000,
        ST_M_LO   = 24'h002000,
        ST_S_LO   = 24'h004000,
        ST_S_EN   = 24'h008000,
        ST_DIVP   = 24'h010000,
        ST_M_PW   = 24'h020000,
        ST_A_PW   = 24'h040000,
        ST_DIVF   = 24'h080000,
        ST_M_FL   = 24'h100000,
        ST_A_FL   = 24'h200000,
        ST_UPD    = 24'h400000,
        ST_FIN    = 24'h800000
    } cem_state_t;

    typedef struct packed {
        logic             done;
        logic             ovf;
        logic [QUO_W-1:0] quo;
    } div_res_t;

    function automatic logic signed [32:0] ema_step(input logic signed [32:0] avg,
                                                    input logic signed [62:0] prod);
        logic signed [62:0] r;
        r = (prod + 63'sd32768) >>> 16;
        return avg + r[32:0];
    endfunction

endpackage

// File: rtl/cem_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cem_div: iterative restoring divider
// One quotient bit per cycle; keeps the low quotient word and flags overflow.
// ----------------------------------------------------------------------------
module cem_div import cem_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DIV_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output div_res_t         res
);

    logic [DIV_W-1:0]  num_reg, num_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic              ovf_reg, ovf_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DEN_W:0]    sh;
    logic              ge;

    always_comb begin
        sh        = {rem_reg, num_reg[DIV_W-1]};
        ge        = sh >= {1'b0, den};
        num_next  = num_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        ovf_next  = ovf_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            num_next  = num;
            rem_next  = '0;
            quo_next  = '0;
            ovf_next  = 1'b0;
            cnt_next  = DCNT_W'(DIV_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            num_next = {num_reg[DIV_W-2:0], 1'b0};
            rem_next = ge ? DEN_W'(sh - {1'b0, den}) : sh[DEN_W-1:0];
            quo_next = {quo_reg[QUO_W-2:0], ge};
            ovf_next = ovf_reg | quo_reg[QUO_W-1];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DCNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        ovf_reg <= ovf_next;
    end

    assign res = '{done: done_reg, ovf: ovf_reg, quo: quo_reg};

endmodule

// File: rtl/coolant_energy_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coolant_energy_monitor: flow pulse qualifier and cooling energy monitor
// Debounces flow pin samples and, on every twentieth tick, smooths
// temperatures and accumulates mass, energy, power and flow with alarms.
//
// channel  dir  handshake                 payload
// s_       in   s_tvalid/s_tready         s_tuser req_type, s_tdata sample
// m_       out  m_tvalid/m_tready         m_tdata result word
// cfg_     in   cfg_wr_en                 cfg_addr, cfg_wdata
//
// Pin items and non-firing ticks go from ST_IDLE straight to ST_FIN. A firing
// tick with good samples and a reference makes two 72-step passes of the shared
// divider and uses the shared multiplier. A bad-sample tick ends after ST_A_INT.
// Reset is synchronous, active low. A waiting result stalls only the final
// step; the next item may be accepted while it waits.
// ----------------------------------------------------------------------------
module coolant_energy_monitor import cem_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [87:0]        s_tdata,  // pin_level, temp_in, temp_out, temp_internal, time_ms
    input  logic               s_tuser,  // req_type
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [231:0]       m_tdata,  // pulse_total, alarm_bits, energy_total, mass_total,
                                         // power_avg, flow_avg, inlet_smoothed,
                                         // outlet_smoothed, internal_smoothed
    input  logic               cfg_wr_en,
    input  logic [CFG_A_W-1:0] cfg_addr,
    input  logic [CFG_D_W-1:0] cfg_wdata
);

    cem_state_t state_reg, state_next;

    logic [15:0]        gpp_reg, hc_reg;
    logic [23:0]        min_flow_reg;
    logic signed [15:0] min_t_reg, max_t_reg;
    logic [4:0]         mask_reg;

    logic signed [4:0]  li_reg;
    logic               armed_reg, have_ref_reg;
    logic [31:0]        pcount_reg, ref_pulses_reg, ref_time_reg;
    logic [4:0]         tdiv_reg;
    logic signed [15:0] in_avg_reg, out_avg_reg, int_avg_reg;
    logic signed [47:0] energy_reg;
    logic [39:0]        mass_acc_reg;
    logic signed [31:0] power_reg;
    logic [23:0]        flow_reg;
    logic [4:0]         alarm_reg;

    logic signed [15:0] ti_reg, to_reg, tn_reg, ni_reg, no_reg;
    logic [31:0]        now_reg, dt_reg;
    logic [47:0]        mass_reg;
    logic               neg_reg;
    logic [16:0]        absd_reg;
    logic [32:0]        a_reg;
    logic [60:0]        mag_reg;
    logic signed [62:0] prod_reg;

    logic               out_valid_reg;
    logic [231:0]       out_reg;

    logic signed [33:0] mul_a;
    logic signed [28:0] mul_b;
    logic               div_start;
    logic [60:0]        k_src;
    logic [DIV_W-1:0]   k_num;
    div_res_t           div_res;

    logic               acc;
    logic signed [5:0]  li_inc;
    logic [4:0]         tdiv_inc;
    logic signed [15:0] s_ti, s_to, s_tn;
    logic [31:0]        dt_now;
    logic               bad;
    logic signed [15:0] int_new, ni_new, no_new;
    logic [31:0]        dp;
    logic signed [16:0] dtemp;
    logic [48:0]        mass_sum;
    logic signed [63:0] j_val, en_sum;
    logic signed [32:0] pw;
    logic [23:0]        flow_q;
    logic [23:0]        flow_new;
    logic signed [32:0] ema_i, ema_in, ema_out, ema_p, ema_f;

    cem_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (k_num),
        .den     (dt_reg),
        .res     (div_res)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign acc      = s_tvalid & s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    assign s_ti   = s_tdata[16:1];
    assign s_to   = s_tdata[32:17];
    assign s_tn   = s_tdata[48:33];
    assign li_inc = s_tdata[0] ? 6'(li_reg) + 6'sd1 : 6'(li_reg) - 6'sd1;
    assign tdiv_inc = tdiv_reg + 5'd1;

    assign dt_now = now_reg - ref_time_reg;
    assign bad    = (ti_reg < 0) || (to_reg < 0) ||
                    (ti_reg > 16'(SENSOR_MAX)) || (to_reg > 16'(SENSOR_MAX));
    assign dp     = pcount_reg - ref_pulses_reg;
    assign dtemp  = 17'(no_reg) - 17'(ni_reg);

    assign ema_i   = ema_step(33'(int_avg_reg), prod_reg);
    assign ema_in  = ema_step(33'(in_avg_reg), prod_reg);
    assign ema_out = ema_step(33'(out_avg_reg), prod_reg);
    assign ema_p   = ema_step(33'(power_reg), prod_reg);
    assign ema_f   = ema_step($signed({9'b0, flow_reg}), prod_reg);
    assign int_new = have_ref_reg ? ema_i[15:0] : tn_reg;
    assign ni_new  = have_ref_reg ? ema_in[15:0] : ti_reg;
    assign no_new  = have_ref_reg ? ema_out[15:0] : to_reg;
    assign flow_new = ema_f[23:0];

    assign mass_sum = {9'b0, mass_acc_reg} + {1'b0, prod_reg[47:0]};
    assign j_val    = neg_reg ? -$signed({3'b0, mag_reg}) : $signed({3'b0, mag_reg});
    assign en_sum   = 64'(energy_reg) + j_val;

    always_comb begin
        if (div_res.ovf || div_res.quo[31]) begin
            pw = neg_reg ? -33'sd2147483648 : 33'sd2147483647;
        end else begin
            pw = neg_reg ? -$signed({1'b0, div_res.quo}) : $signed({1'b0, div_res.quo});
        end
        if (div_res.ovf || div_res.quo[31:24] != 8'd0) begin
            flow_q = 24'hFFFFFF;
        end else begin
            flow_q = div_res.quo[23:0];
        end
    end

    assign k_src = (state_reg == ST_A_PW) ? {13'b0, mass_reg} : mag_reg;
    assign k_num = ({11'b0, k_src} << 10) - ({11'b0, k_src} << 4) - ({11'b0, k_src} << 3);
    assign div_start = (state_reg == ST_S_EN) || (state_reg == ST_A_PW);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_M_INT: begin
                mul_a = 34'(tn_reg) - 34'(int_avg_reg);
                mul_b = 29'(EMA_ALPHA);
            end
            ST_M_IN: begin
                mul_a = 34'(ti_reg) - 34'(in_avg_reg);
                mul_b = 29'(EMA_ALPHA);
            end
            ST_M_OUT: begin
                mul_a = 34'(to_reg) - 34'(out_avg_reg);
                mul_b = 29'(EMA_ALPHA);
            end
            ST_M_MASS: begin
                mul_a = $signed({2'b0, dp});
                mul_b = $signed({13'b0, gpp_reg});
            end
            ST_M_A: begin
                mul_a = $signed({17'b0, absd_reg});
                mul_b = $signed({13'b0, hc_reg});
            end
            ST_M_HI: begin
                mul_a = $signed({1'b0, a_reg});
                mul_b = $signed({1'b0, mass_reg[47:20]});
            end
            ST_M_LO: begin
                mul_a = $signed({1'b0, a_reg});
                mul_b = $signed({9'b0, mass_reg[19:0]});
            end
            ST_M_PW: begin
                mul_a = 34'(pw) - 34'(power_reg);
                mul_b = 29'(EMA_ALPHA);
            end
            ST_M_FL: begin
                mul_a = $signed({10'b0, flow_q}) - $signed({10'b0, flow_reg});
                mul_b = 29'(EMA_ALPHA);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    state_next = (s_tuser && tdiv_inc > 5'(TICK_DIVIDE - 1)) ? ST_M_INT : ST_FIN;
                end
            end
            ST_M_INT:  state_next = ST_A_INT;
            ST_A_INT:  state_next = bad ? ST_FIN : ST_M_IN;
            ST_M_IN:   state_next = ST_A_IN;
            ST_A_IN:   state_next = ST_M_OUT;
            ST_M_OUT:  state_next = ST_A_OUT;
            ST_A_OUT:  state_next = (have_ref_reg && dt_reg != 32'd0) ? ST_M_MASS : ST_UPD;
            ST_M_MASS: state_next = ST_A_MASS;
            ST_A_MASS: state_next = ST_M_A;
            ST_M_A:    state_next = ST_S_A;
            ST_S_A:    state_next = ST_M_HI;
            ST_M_HI:   state_next = ST_S_HI;
            ST_S_HI:   state_next = ST_M_LO;
            ST_M_LO:   state_next = ST_S_LO;
            ST_S_LO:   state_next = ST_S_EN;
            ST_S_EN:   state_next = ST_DIVP;
            ST_DIVP:   state_next = div_res.done ? ST_M_PW : ST_DIVP;
            ST_M_PW:   state_next = ST_A_PW;
            ST_A_PW:   state_next = ST_DIVF;
            ST_DIVF:   state_next = div_res.done ? ST_M_FL : ST_DIVF;
            ST_M_FL:   state_next = ST_A_FL;
            ST_A_FL:   state_next = ST_UPD;
            ST_UPD:    state_next = ST_FIN;
            ST_FIN:    state_next = (!out_valid_reg || m_tready) ? ST_IDLE : ST_FIN;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            gpp_reg        <= 16'd512;
            hc_reg         <= 16'd17146;
            min_flow_reg   <= 24'd2560;
            min_t_reg      <= 16'sd1280;
            max_t_reg      <= 16'sd7680;
            mask_reg       <= '0;
            li_reg         <= '0;
            armed_reg      <= 1'b0;
            have_ref_reg   <= 1'b0;
            pcount_reg     <= '0;
            ref_pulses_reg <= '0;
            ref_time_reg   <= '0;
            tdiv_reg       <= '0;
            in_avg_reg     <= '0;
            out_avg_reg    <= '0;
            int_avg_reg    <= '0;
            energy_reg     <= '0;
            mass_acc_reg   <= '0;
            power_reg      <= '0;
            flow_reg       <= '0;
            alarm_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_GRAMS_PER_PULSE: gpp_reg      <= cfg_wdata[15:0];
                    REG_HEAT_CAPACITY:   hc_reg       <= cfg_wdata[15:0];
                    REG_MIN_FLOW:        min_flow_reg <= cfg_wdata;
                    REG_MIN_WATER_TEMP:  min_t_reg    <= cfg_wdata[15:0];
                    REG_MAX_WATER_TEMP:  max_t_reg    <= cfg_wdata[15:0];
                    REG_ALARM_MASK:      mask_reg     <= cfg_wdata[4:0];
                    default: ;
                endcase
            end
            if ((state_reg == ST_FIN) && (!out_valid_reg || m_tready)) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (acc && !s_tuser) begin
                        if (li_inc > 6'(DEBOUNCE_LIMIT)) begin
                            li_reg <= 5'(DEBOUNCE_LIMIT);
                            if (armed_reg) begin
                                pcount_reg <= pcount_reg + 32'd1;
                                armed_reg  <= 1'b0;
                            end
                        end else if (li_inc < -6'(DEBOUNCE_LIMIT)) begin
                            li_reg    <= -5'(DEBOUNCE_LIMIT);
                            armed_reg <= 1'b1;
                        end else begin
                            li_reg <= li_inc[4:0];
                        end
                    end else if (acc) begin
                        tdiv_reg <= (tdiv_inc > 5'(TICK_DIVIDE - 1)) ? 5'd0 : tdiv_inc;
                    end
                end
                ST_A_INT: begin
                    int_avg_reg <= int_new;
                    alarm_reg   <= {3'b0,
                                    bad && (dt_now > 32'(SENSOR_TIMEOUT_MS)),
                                    int_new > 16'(OVERTEMP_LIMIT)};
                end
                ST_A_MASS: begin
                    mass_acc_reg <= (mass_sum > 49'hFF_FFFF_FFFF) ? 40'hFF_FFFF_FFFF
                                                                  : mass_sum[39:0];
                end
                ST_S_EN: begin
                    if (en_sum > 64'sh7FFF_FFFF_FFFF) begin
                        energy_reg <= 48'sh7FFF_FFFF_FFFF;
                    end else if (en_sum < -64'sh8000_0000_0000) begin
                        energy_reg <= 48'sh8000_0000_0000;
                    end else begin
                        energy_reg <= en_sum[47:0];
                    end
                end
                ST_A_PW: power_reg <= ema_p[31:0];
                ST_A_FL: begin
                    flow_reg     <= flow_new;
                    alarm_reg[2] <= flow_new < min_flow_reg;
                    alarm_reg[3] <= (no_reg < min_t_reg) || (ni_reg < min_t_reg);
                    alarm_reg[4] <= (no_reg > max_t_reg) || (ni_reg > max_t_reg);
                end
                ST_UPD: begin
                    ref_pulses_reg <= pcount_reg;
                    ref_time_reg   <= now_reg;
                    have_ref_reg   <= 1'b1;
                    in_avg_reg     <= ni_reg;
                    out_avg_reg    <= no_reg;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (acc) begin
            ti_reg  <= s_ti;
            to_reg  <= s_to;
            tn_reg  <= s_tn;
            now_reg <= s_tdata[80:49];
        end
        case (state_reg)
            ST_A_INT:  dt_reg <= dt_now;
            ST_A_IN:   ni_reg <= ni_new;
            ST_A_OUT:  no_reg <= no_new;
            ST_A_MASS: begin
                mass_reg <= prod_reg[47:0];
                neg_reg  <= dtemp < 0;
                absd_reg <= (dtemp < 0) ? 17'(-dtemp) : 17'(dtemp);
            end
            ST_S_A:    a_reg   <= prod_reg[32:0];
            ST_S_HI:   mag_reg <= prod_reg[60:0];
            ST_S_LO:   mag_reg <= mag_reg + {20'b0, prod_reg[60:20]};
            ST_FIN: begin
                if (!out_valid_reg || m_tready) begin
                    out_reg <= {3'b0, int_avg_reg, out_avg_reg, in_avg_reg, flow_reg,
                                power_reg, mass_acc_reg, energy_reg,
                                alarm_reg & ~mask_reg, pcount_reg};
                end
            end
            default: ;
        endcase
    end

`ifndef SYNTH
    a_state_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_li_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (li_reg <= 5'(DEBOUNCE_LIMIT)) && (li_reg >= -5'(DEBOUNCE_LIMIT)))
        else $error("level integrator out of range");

    a_tdiv_range: assert property (@(posedge aclk) disable iff (!aresetn)
        tdiv_reg < 5'(TICK_DIVIDE))
        else $error("tick divider out of range");

    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_res.done |-> (state_reg == ST_DIVP) || (state_reg == ST_DIVF))
        else $error("divider finished outside a divide step");
`endif

endmodule
